>>> design/fetc_pkg.sv
package fetc_pkg;

	// Fixed-point sample width of z and c
	localparam int unsigned FIX_W = 32;

	// Product width of two samples
	localparam int unsigned PROD_W = 2 * FIX_W;

	// Iteration limit register width and reset value
	localparam int unsigned LIMIT_W = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

	// Configuration port
	localparam int unsigned APB_DW = 32;
	localparam int unsigned APB_AW = 3;
	localparam logic REG_LIMIT = 1'b0;

	// Result count width on the result channel
	localparam int unsigned RES_CNT_W = 16;

	typedef logic signed [FIX_W-1:0] fix_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Point state handed from cell to cell around the ring
	typedef struct packed {
		logic pending;  // z came from a step; its magnitude is still unchecked
		logic done;
		logic bounded;
		fix_t zr;
		fix_t zi;
		fix_t cr;
		fix_t ci;
	} tok_t;

endpackage

>>> design/fetc_point_if.sv
interface fetc_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] start_re;
	logic signed [31:0] start_im;
	logic signed [31:0] const_re;
	logic signed [31:0] const_im;

	modport source (
		output valid, start_re, start_im, const_re, const_im,
		input ready
	);

	modport sink (
		input valid, start_re, start_im, const_re, const_im,
		output ready
	);
endinterface

>>> design/fetc_result_if.sv
interface fetc_result_if;
	logic valid;
	logic ready;
	logic [15:0] iteration_count;
	logic stayed_bounded;

	modport source (
		output valid, iteration_count, stayed_bounded,
		input ready
	);

	modport sink (
		input valid, iteration_count, stayed_bounded,
		output ready
	);
endinterface

>>> design/fetc_cell.sv
module fetc_cell
	import fetc_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 28,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [COUNT_BITS-1:0] limit,
	input  logic in_vld,
	input  tok_t in_tok,
	input  logic [COUNT_BITS-1:0] in_cnt,
	output logic out_vld,
	output tok_t out_tok,
	output logic [COUNT_BITS-1:0] out_cnt
);

	localparam logic [PROD_W-1:0] BOUND = 64'd4 << FRAC_BITS;

	logic vld_s1, vld_s2;
	tok_t tok_s1, tok_s2;
	logic [COUNT_BITS-1:0] cnt_s1, cnt_s2;
	prod_t rr_s1, ii_s1, ri_s1;

	logic [PROD_W-1:0] mag;
	logic big;
	logic signed [PROD_W+1:0] sr, si, pc, cr_x, ci_x, nr, ni;
	logic ovf;
	logic [COUNT_BITS-1:0] cnt_inc;
	tok_t nxt_tok;
	logic [COUNT_BITS-1:0] nxt_cnt;

	// Form the two squares and the cross product of z
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= in_tok;
		cnt_s1 <= in_cnt;
		rr_s1  <= in_tok.zr * in_tok.zr;
		ii_s1  <= in_tok.zi * in_tok.zi;
		ri_s1  <= in_tok.zr * in_tok.zi;
	end

	// Check the magnitude of z, then build the next z from the same products
	assign mag  = $unsigned(rr_s1) + $unsigned(ii_s1);
	assign big  = (mag >> FRAC_BITS) > BOUND;
	assign sr   = rr_s1 >>> FRAC_BITS;
	assign si   = ii_s1 >>> FRAC_BITS;
	assign pc   = ri_s1 >>> (FRAC_BITS - 1);
	assign cr_x = tok_s1.cr;
	assign ci_x = tok_s1.ci;
	assign nr   = sr - si + cr_x;
	assign ni   = pc + ci_x;
	assign ovf  = !((&nr[PROD_W+1:FIX_W-1]) || !(|nr[PROD_W+1:FIX_W-1]))
		|| !((&ni[PROD_W+1:FIX_W-1]) || !(|ni[PROD_W+1:FIX_W-1]));
	assign cnt_inc = cnt_s1 + COUNT_BITS'(tok_s1.pending);

	always_comb begin
		nxt_tok = tok_s1;
		nxt_cnt = cnt_s1;
		if (!tok_s1.done) begin
			if (tok_s1.pending && big) begin
				nxt_tok.done    = 1'b1;
				nxt_tok.bounded = 1'b0;
			end else begin
				nxt_cnt = cnt_inc;
				if (cnt_inc == limit) begin
					nxt_tok.done    = 1'b1;
					nxt_tok.bounded = 1'b1;
				end else if (ovf) begin
					nxt_tok.done    = 1'b1;
					nxt_tok.bounded = 1'b0;
				end else begin
					nxt_tok.zr      = nr[FIX_W-1:0];
					nxt_tok.zi      = ni[FIX_W-1:0];
					nxt_tok.pending = 1'b1;
				end
			end
		end
	end

	// Hand the point to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s2 <= nxt_tok;
		cnt_s2 <= nxt_cnt;
	end

	assign out_vld = vld_s2;
	assign out_tok = tok_s2;
	assign out_cnt = cnt_s2;

endmodule

>>> design/fractal_escape_time_counter.sv
// Escape-time counter: a ring of CELLS cells, each doing one z*z + c step.
// One point at a time circulates the ring. A point that stops at the limit, overflows or
// escapes leaves the ring at the end of a whole lap, once the output register is free,
// and a new point is accepted only after the previous one has left the ring.
// The next point is taken while a finished result waits in the output register.
// Reset clears the ring, the busy flag and the output valid, and sets the limit to 256.
module fractal_escape_time_counter
	import fetc_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 28,
	parameter int unsigned COUNT_BITS = 16,
	parameter int unsigned CELLS = 2
) (
	input  logic clk,
	input  logic arst_n,
	fetc_point_if.sink point,
	fetc_result_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready
);

	localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

	logic [LIMIT_W-1:0] limit_q;
	logic [COUNT_BITS-1:0] eff_limit;
	logic [31:0] lim_wide;
	logic busy_q;
	logic out_vld_q;
	logic [RES_CNT_W-1:0] out_cnt_q;
	logic out_bnd_q;
	logic out_free, acc, capture;
	logic [CELLS:0] vld_l;
	tok_t tok_l [CELLS+1];
	logic [COUNT_BITS-1:0] cnt_l [CELLS+1];
	tok_t init_tok;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIMIT) ? APB_DW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// Clamp the limit to what the counter holds
	assign lim_wide  = 32'(limit_q);
	assign eff_limit = COUNT_BITS'((lim_wide > CMAX) ? CMAX : lim_wide);

	// Inject a new point or recirculate the one in the ring
	assign out_free = !out_vld_q || result.ready;
	assign acc      = point.valid && !busy_q;
	assign capture  = vld_l[CELLS] && tok_l[CELLS].done && out_free;
	assign point.ready = !busy_q;

	always_comb begin
		init_tok         = '0;
		init_tok.zr      = point.start_re;
		init_tok.zi      = point.start_im;
		init_tok.cr      = point.const_re;
		init_tok.ci      = point.const_im;
	end

	assign vld_l[0] = acc || (vld_l[CELLS] && !capture);
	assign tok_l[0] = acc ? init_tok : tok_l[CELLS];
	assign cnt_l[0] = acc ? '0 : cnt_l[CELLS];

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		fetc_cell #(
			.FRAC_BITS(FRAC_BITS),
			.COUNT_BITS(COUNT_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.limit(eff_limit),
			.in_vld(vld_l[g]),
			.in_tok(tok_l[g]),
			.in_cnt(cnt_l[g]),
			.out_vld(vld_l[g+1]),
			.out_tok(tok_l[g+1]),
			.out_cnt(cnt_l[g+1])
		);
	end

	// Track the point in flight and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (capture) begin
				busy_q <= 1'b0;
			end
			if (capture) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_cnt_q <= RES_CNT_W'(cnt_l[CELLS]);
			out_bnd_q <= tok_l[CELLS].bounded;
		end
	end

	assign result.valid           = out_vld_q;
	assign result.iteration_count = out_cnt_q;
	assign result.stayed_bounded  = out_bnd_q;

	// At most one point lives in the ring
	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_l[CELLS:1]) <= 1)
		else $error("more than one point in the ring");

	// A point in the ring means the block is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_l[CELLS] |-> busy_q)
		else $error("ring holds a point while idle");

	// A bounded result carries the full limit
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.stayed_bounded) |->
		(result.iteration_count == RES_CNT_W'(eff_limit)))
		else $error("bounded result with short count");

endmodule

>>> dv/fetc_point_if.sv
// The point and result channel interfaces are taken from the design folder.

>>> dv/tb_fractal_escape_time_counter.sv
module tb_fractal_escape_time_counter;
	import fetc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAC = 28;
	localparam longint unsigned CNT_MAX = 65535;
	localparam longint unsigned RUN_LIMIT = 8000000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [15:0] count;
		logic bounded;
	} escape_t;

	typedef struct {
		logic [15:0] limit;
		fix_t zr, zi, cr, ci;
		bit known;
		logic [15:0] count;
		logic bounded;
	} point_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	fetc_point_if point ();
	fetc_result_if result ();

	fractal_escape_time_counter DUT (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	escape_t escape_q[$];
	logic [15:0] iter_limit;
	int unsigned errors;
	int unsigned src_idle;
	int unsigned snk_idle;
	longint unsigned cycles;

	// Escape count of one point under the given limit
	function automatic escape_t predict_escape(fix_t zr_in, fix_t zi_in, fix_t cr_in,
			fix_t ci_in, logic [15:0] lim);
		longint zr, zi, cr, ci, sr, si, pc, nr, ni;
		longint unsigned limit, n, mag;
		bit escaped;
		escape_t r;
		zr = zr_in; zi = zi_in; cr = cr_in; ci = ci_in;
		limit = lim;
		if (limit > CNT_MAX) limit = CNT_MAX;
		n = 0;
		escaped = 0;
		while (n < limit) begin
			sr = (zr * zr) >>> FRAC;
			si = (zi * zi) >>> FRAC;
			pc = (zr * zi) >>> (FRAC - 1);
			nr = sr - si + cr;
			ni = pc + ci;
			if (nr < -64'sh80000000 || nr > 64'sh7FFFFFFF ||
					ni < -64'sh80000000 || ni > 64'sh7FFFFFFF) begin
				escaped = 1;
				break;
			end
			zr = nr;
			zi = ni;
			mag = longint'(zr * zr) + longint'(zi * zi);
			if ((mag >> FRAC) > (64'd4 << FRAC)) begin
				escaped = 1;
				break;
			end
			n++;
		end
		r.count = n[15:0];
		r.bounded = (!escaped && n == limit);
		return r;
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Cycle guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("tb_fractal_escape_time_counter: FAIL");
			$finish;
		end
	end

	// Result back-pressure
	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= snk_idle);
	end

	// Compare each accepted result beat against the oldest prediction
	always @(posedge clk) begin
		escape_t want;
		if (arst_n && result.valid && result.ready) begin
			if (escape_q.size() == 0) begin
				$display("%0t unexpected result count=%0d bounded=%0b", $time,
					result.iteration_count, result.stayed_bounded);
				errors++;
			end else begin
				want = escape_q.pop_front();
				if (result.iteration_count !== want.count) begin
					$display("%0t iteration_count exp %0d got %0d", $time, want.count,
						result.iteration_count);
					errors++;
				end
				if (result.stayed_bounded !== want.bounded) begin
					$display("%0t stayed_bounded exp %0b got %0b", $time, want.bounded,
						result.stayed_bounded);
					errors++;
				end
			end
		end
	end

	// Write the limit register, then read it back
	task automatic write_limit(logic [15:0] value);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= APB_AW'(4 * REG_LIMIT); pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		penable <= 0; pwrite <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[15:0] !== value) begin
			$display("%0t limit readback exp %0d got %0d", $time, value, prdata[15:0]);
			errors++;
		end
		psel <= 0; penable <= 0;
		iter_limit = value;
		@(posedge clk);
	endtask

	// Hold off until every result is in, then let the block settle
	task automatic drain();
		point.valid <= 0;
		@(posedge clk);
		while (escape_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Send one point beat; optionally check against a typed-in result
	task automatic send_point(fix_t zr, fix_t zi, fix_t cr, fix_t ci, bit known,
			escape_t typed);
		escape_t want;
		while ($urandom_range(99) < src_idle) begin
			point.valid <= 0;
			@(posedge clk);
		end
		point.valid <= 1;
		point.start_re <= zr; point.start_im <= zi;
		point.const_re <= cr; point.const_im <= ci;
		do @(posedge clk); while (!point.ready);
		want = predict_escape(zr, zi, cr, ci, iter_limit);
		if (known && want !== typed) begin
			$display("%0t predictor exp %0d/%0b table %0d/%0b", $time, want.count,
				want.bounded, typed.count, typed.bounded);
			errors++;
		end
		escape_q.push_back(known ? typed : want);
	endtask

	// Random coordinate within +-2.0, or any 32-bit pattern
	function automatic fix_t rand_coord(bit full);
		if (full) return fix_t'($urandom);
		return fix_t'($signed({1'b0, $urandom_range(32'h40000000, 0)}) - 32'sh20000000);
	endfunction

	point_row_t rows[$];

	task automatic add_row(logic [15:0] lim, fix_t zr, fix_t zi, fix_t cr, fix_t ci,
			bit known, logic [15:0] cnt, logic bnd);
		point_row_t r;
		r.limit = lim; r.zr = zr; r.zi = zi; r.cr = cr; r.ci = ci;
		r.known = known; r.count = cnt; r.bounded = bnd;
		rows.push_back(r);
	endtask

	initial begin
		escape_t typed;
		bit full, mandel;
		logic [15:0] lim;
		cycles = 0;
		errors = 0;
		src_idle = 0;
		snk_idle = 0;
		iter_limit = LIMIT_RESET;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		point.valid = 0;
		point.start_re = '0; point.start_im = '0;
		point.const_re = '0; point.const_im = '0;
		result.ready = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed rows: reset limit, then zero, one and the top limit
		add_row(256, 0, 0, 0, 0, 1, 256, 1);
		add_row(256, 0, 0, 32'sh28000000, 0, 1, 0, 0);
		add_row(256, 0, 0, -32'sh20000000, 0, 1, 256, 1);
		add_row(256, 0, 0, 0, 32'sh10000000, 0, 0, 0);
		add_row(256, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 0, 0);
		add_row(256, -32'sh80000000, -32'sh80000000, -32'sh80000000, -32'sh80000000,
			1, 0, 0);
		add_row(256, 32'sh20000000, 0, 0, 0, 1, 0, 0);
		add_row(256, 32'sh08000000, 32'sh08000000, -32'sh0C000000, 32'sh01999999, 0, 0, 0);
		add_row(256, 0, 0, 32'sh04000000, 0, 0, 0, 0);
		add_row(256, 32'sh5A5A5A5A, -32'sh25A5A5A6, 32'sh0F0F0F0F, -32'sh70F0F0F1, 0, 0, 0);
		add_row(256, 0, 0, -32'sh1D000000, 32'sh00400000, 0, 0, 0);
		add_row(0, 0, 0, 32'sh28000000, 0, 1, 0, 1);
		add_row(0, 0, 0, 0, 0, 1, 0, 1);
		add_row(1, 0, 0, 32'sh28000000, 0, 1, 0, 0);
		add_row(1, 0, 0, 0, 0, 1, 1, 1);
		add_row(65535, 0, 0, 32'sh28000000, 0, 1, 0, 0);
		add_row(65535, 0, 0, 0, 0, 1, 65535, 1);

		foreach (rows[i]) begin
			if (rows[i].limit != iter_limit) begin
				drain();
				write_limit(rows[i].limit);
			end
			typed.count = rows[i].count;
			typed.bounded = rows[i].bounded;
			send_point(rows[i].zr, rows[i].zi, rows[i].cr, rows[i].ci, rows[i].known, typed);
		end
		drain();

		// Random chunks under three idling modes, limit changed between chunks
		typed = '0;
		for (int mode = 0; mode < 3; mode++) begin
			src_idle = (mode == 0) ? 23 : (mode == 1) ? 71 : 0;
			snk_idle = (mode == 0) ? 71 : (mode == 1) ? 23 : 0;
			for (int chunk = 0; chunk < 6; chunk++) begin
				lim = ($urandom_range(9) == 0) ? 16'($urandom_range(255, 100)) :
					16'($urandom_range(48, 1));
				write_limit(lim);
				for (int k = 0; k < 100; k++) begin
					full = ($urandom_range(99) < 30);
					mandel = ($urandom_range(1) == 0);
					if (mandel && !full)
						send_point(0, 0, rand_coord(0), rand_coord(0), 0, typed);
					else
						send_point(rand_coord(full), rand_coord(full), rand_coord(full),
							rand_coord(full), 0, typed);
				end
				drain();
			end
		end

		if (errors == 0)
			$display("tb_fractal_escape_time_counter: PASS");
		else
			$display("tb_fractal_escape_time_counter: FAIL");
		$finish;
	end

endmodule

>>> sim.f
design/fetc_pkg.sv
design/fetc_point_if.sv
design/fetc_result_if.sv
design/fetc_cell.sv
design/fractal_escape_time_counter.sv
dv/fetc_point_if.sv
dv/tb_fractal_escape_time_counter.sv
